// ===== rtl/bpl_pkg.sv =====
package bpl_pkg;

	typedef struct packed {
		logic [2:0] command;
		logic       is_request;
		logic [7:0] seq_number;
		logic       block_start;
		logic [6:0] block_count;
		logic [3:0] data_length;
		logic [7:0] in_byte0;
		logic [7:0] in_byte1;
		logic [7:0] in_byte2;
		logic [7:0] in_byte3;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  reply_command;
		logic [1:0]  reply_status;
		logic [7:0]  reply_number;
		logic [3:0]  reply_length;
		logic [7:0]  out_byte0;
		logic [7:0]  out_byte1;
		logic [7:0]  out_byte2;
		logic [7:0]  out_byte3;
		logic [15:0] flash_page;
		logic [4:0]  word_index;
		logic        last;
	} out_word_t;

	localparam logic [2:0] CMD_IDENTIFY    = 3'd0;
	localparam logic [2:0] CMD_SET_ADDRESS = 3'd1;
	localparam logic [2:0] CMD_DATA        = 3'd2;
	localparam logic [2:0] CMD_START_APP   = 3'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_WRONG = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_FLASH = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [1:0] REG_ID_VERSION = 2'd0;
	localparam logic [1:0] REG_PAGE_SIZE  = 2'd1;
	localparam logic [1:0] REG_PAGES      = 2'd2;

	// Decision taken for one message
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_ONE,
		ACT_START,
		ACT_FLUSH
	} act_t;

	typedef struct packed {
		logic      take;
		logic      dump_rd;
		logic      emit_first;
		logic      emit_dump;
		logic      emit_start;
	} bpl_cmd_t;

	typedef struct packed {
		act_t      act;
	} bpl_stat_t;

endpackage

// ===== rtl/bpl_datapath.sv =====
module bpl_datapath #(
	parameter int PAGE_BYTES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpl_pkg::in_word_t  in_word,
	input  bpl_pkg::bpl_cmd_t  cmd,
	output bpl_pkg::bpl_stat_t stat,
	input  logic [7:0]         id_version_byte,
	input  logic [7:0]         page_size_code,
	input  logic [15:0]        writable_pages,
	output bpl_pkg::out_word_t res
);
	import bpl_pkg::*;

	localparam int PW = PAGE_BYTES / 4;
	localparam int AW = $clog2(PW);

	logic [7:0]  expected_seq_q;
	logic        collecting_q;
	logic [15:0] target_page_q;
	logic [5:0]  fill_position_q;
	logic [7:0]  expected_block_count_q;
	logic [31:0] mem_q [PW];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] wr_idx_q;
	out_word_t   first_q;
	logic [15:0] flush_page_q;

	logic [7:0]  nxt;
	logic [15:0] pg;
	out_word_t   r;
	act_t        act;
	logic        coll_n;
	logic [15:0] tp_n;
	logic [5:0]  fp_n;
	logic [7:0]  ebc_n;
	logic [7:0]  ebc_eff;
	logic        wr_en;
	logic [5:0]  fp_inc;

	// Decide the message outcome
	always_comb begin
		nxt = expected_seq_q + 8'd1;
		pg = {in_word.in_byte0, in_word.in_byte1};
		r = '0;
		r.reply_command = in_word.command;
		r.reply_number = nxt;
		r.reply_status = ST_ERROR;
		r.reply_length = in_word.data_length;
		r.out_byte0 = in_word.in_byte0;
		r.out_byte1 = in_word.in_byte1;
		r.out_byte2 = in_word.in_byte2;
		r.out_byte3 = in_word.in_byte3;
		r.last = 1'b1;
		act = ACT_ONE;
		coll_n = collecting_q;
		tp_n = target_page_q;
		fp_n = fill_position_q;
		ebc_n = expected_block_count_q;
		ebc_eff = expected_block_count_q;
		wr_en = 1'b0;
		fp_inc = fill_position_q + 6'd1;
		if (!in_word.is_request) begin
			act = ACT_NONE;
		end else if (in_word.seq_number != nxt) begin
			r.reply_status = ST_WRONG;
			r.reply_length = '0;
			r.out_byte0 = '0;
			r.out_byte1 = '0;
			r.out_byte2 = '0;
			r.out_byte3 = '0;
		end else begin
			unique case (in_word.command)
				CMD_IDENTIFY: begin
					r.reply_status = ST_OK;
					r.reply_length = 4'd4;
					r.out_byte0 = id_version_byte;
					r.out_byte1 = page_size_code;
					r.out_byte2 = writable_pages[15:8];
					r.out_byte3 = writable_pages[7:0];
				end
				CMD_SET_ADDRESS: begin
					if (in_word.data_length == 4'd4 && {24'd0, in_word.in_byte3} < PW
						&& pg < writable_pages) begin
						tp_n = pg;
						fp_n = in_word.in_byte3[5:0];
						coll_n = 1'b1;
						r.reply_status = ST_OK;
					end
				end
				CMD_DATA: begin
					if (in_word.data_length != 4'd4 || {26'd0, fill_position_q} >= PW
						|| !collecting_q) begin
						coll_n = 1'b0;
					end else begin
						if (in_word.block_start) begin
							ebc_eff = {1'b0, in_word.block_count};
							coll_n = 1'b1;
						end
						if ({1'b0, in_word.block_count} != ebc_eff) begin
							coll_n = 1'b0;
							ebc_n = ebc_eff;
						end else begin
							ebc_n = ebc_eff - 8'd1;
							wr_en = 1'b1;
							fp_n = fp_inc;
							if (in_word.block_count != 7'd0) begin
								act = ACT_NONE;
							end else if ({26'd0, fp_inc} == PW) begin
								r.reply_length = 4'd2;
								r.out_byte0 = target_page_q[15:8];
								r.out_byte1 = target_page_q[7:0];
								if (target_page_q >= writable_pages) begin
									r.reply_status = ST_ERROR;
								end else begin
									r.reply_status = ST_OK;
									r.out_byte2 = '0;
									r.out_byte3 = '0;
									act = ACT_FLUSH;
									fp_n = '0;
									tp_n = target_page_q + 16'd1;
								end
							end else begin
								r.reply_status = ST_OK;
								r.reply_length = '0;
								r.out_byte0 = '0;
								r.out_byte1 = '0;
								r.out_byte2 = '0;
								r.out_byte3 = '0;
							end
						end
					end
				end
				CMD_START_APP: begin
					r.reply_status = ST_OK;
					r.reply_length = '0;
					r.out_byte0 = '0;
					r.out_byte1 = '0;
					r.out_byte2 = '0;
					r.out_byte3 = '0;
					r.last = 1'b0;
					act = ACT_START;
				end
				default: ;
			endcase
		end
		stat.act = act;
	end

	// Update protocol state on accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_seq_q <= 8'hff;
			collecting_q <= 1'b0;
			target_page_q <= '0;
			fill_position_q <= '0;
			expected_block_count_q <= '0;
		end else if (cmd.take && in_word.is_request && in_word.seq_number == nxt) begin
			expected_seq_q <= nxt;
			collecting_q <= coll_n;
			target_page_q <= tp_n;
			fill_position_q <= fp_n;
			expected_block_count_q <= ebc_n;
		end
	end

	// Page store write, flush read
	always_ff @(posedge clk) begin
		if (cmd.take && wr_en && act != ACT_NONE || cmd.take && wr_en)
			mem_q[fill_position_q[AW-1:0]] <= {in_word.in_byte3, in_word.in_byte2,
				in_word.in_byte1, in_word.in_byte0};
		if (cmd.take) begin
			first_q <= r;
			flush_page_q <= target_page_q;
			rd_idx_q <= '0;
		end else if (cmd.dump_rd) begin
			rd_q <= mem_q[rd_idx_q];
			wr_idx_q <= rd_idx_q;
			rd_idx_q <= rd_idx_q + AW'(1);
		end
	end

	// Select the result word
	always_comb begin
		res = '0;
		if (cmd.emit_first) begin
			res = first_q;
		end else if (cmd.emit_dump) begin
			res.kind = KIND_FLASH;
			res.out_byte0 = rd_q[7:0];
			res.out_byte1 = rd_q[15:8];
			res.out_byte2 = rd_q[23:16];
			res.out_byte3 = rd_q[31:24];
			res.flash_page = flush_page_q;
			res.word_index = 5'(wr_idx_q);
		end else if (cmd.emit_start) begin
			res.kind = KIND_START;
			res.last = 1'b1;
		end
	end

endmodule

// ===== rtl/bpl_ctrl.sv =====
module bpl_ctrl #(
	parameter int PAGE_BYTES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  bpl_pkg::bpl_stat_t stat,
	input  bpl_pkg::out_word_t res,
	output bpl_pkg::bpl_cmd_t  cmd,
	output bpl_pkg::out_word_t out_word
);
	import bpl_pkg::*;

	localparam int PW = PAGE_BYTES / 4;
	localparam int CW = $clog2(PW + 1);

	typedef enum logic [2:0] {S_IDLE, S_REPLY, S_START, S_READ, S_WORD, S_ACK} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic           ov_q;
	out_word_t      ow_q;
	logic           load;
	logic           free;

	assign free = !ov_q || out_ready;
	assign in_ready = state_q == S_IDLE;
	assign out_valid = ov_q;
	assign out_word = ow_q;

	// Drive datapath commands
	always_comb begin
		cmd = '0;
		cmd.take = in_valid && in_ready;
		load = 1'b0;
		unique case (state_q)
			S_REPLY: begin
				cmd.emit_first = 1'b1;
				load = free;
			end
			S_START: begin
				cmd.emit_start = 1'b1;
				load = free;
			end
			S_READ: cmd.dump_rd = 1'b1;
			S_WORD: begin
				cmd.emit_dump = 1'b1;
				load = free;
				cmd.dump_rd = free;
			end
			S_ACK: begin
				cmd.emit_first = 1'b1;
				load = free;
			end
			default: ;
		endcase
	end

	// Hold state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ov_q <= 1'b0;
			ow_q <= '0;
		end else begin
			if (out_ready) ov_q <= 1'b0;
			if (load) begin
				ov_q <= 1'b1;
				ow_q <= res;
			end
			unique case (state_q)
				S_IDLE: if (cmd.take) begin
					unique case (stat.act)
						ACT_NONE: state_q <= S_IDLE;
						ACT_FLUSH: begin
							state_q <= S_READ;
							cnt_q <= '0;
						end
						default: state_q <= S_REPLY;
					endcase
				end
				S_REPLY: if (free) state_q <= res.last ? S_IDLE : S_START;
				S_START: if (free) state_q <= S_IDLE;
				S_READ: state_q <= S_WORD;
				S_WORD: if (free) begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(PW - 1)) state_q <= S_ACK;
				end
				S_ACK: if (free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/boot_page_loader_protocol.sv =====
// Boot page loader protocol engine.
// Input channel (in_valid/in_ready/in_word) takes one received loader
// message; output channel (out_valid/out_ready/out_word) gives results:
// replies, flash word writes and a start signal, the final one with last set.
// Registers via APB: 0 id_version_byte, 1 page_size_code, 2 writable_pages.
// One message at a time: in_ready is high only while the controller is idle.
// A plain reply passes through the REPLY state; start app adds one result.
// A full page flush reads the page store one word per cycle while the
// receiver is ready and emits PAGE_BYTES/4 flash words plus an acknowledge.
// Non-requests and mid-block data give no result; the controller stays idle.
// A stalled receiver holds the output register; the controller waits.
// Reset clears the sequence state (expected number 255), the registers
// and collection state; the page store is undefined until written.
module boot_page_loader_protocol #(
	parameter int PAGE_BYTES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpl_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output bpl_pkg::out_word_t out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import bpl_pkg::*;

	logic [7:0]  id_version_byte_q;
	logic [7:0]  page_size_code_q;
	logic [15:0] writable_pages_q;
	bpl_cmd_t    cmd;
	bpl_stat_t   stat;
	out_word_t   res;

	assign pready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_version_byte_q <= '0;
			page_size_code_q <= '0;
			writable_pages_q <= '0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			unique case (paddr[3:2])
				REG_ID_VERSION: id_version_byte_q <= pwdata[7:0];
				REG_PAGE_SIZE:  page_size_code_q <= pwdata[7:0];
				REG_PAGES:      writable_pages_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_ID_VERSION: prdata = {24'd0, id_version_byte_q};
			REG_PAGE_SIZE:  prdata = {24'd0, page_size_code_q};
			REG_PAGES:      prdata = {16'd0, writable_pages_q};
			default: ;
		endcase
	end

	bpl_datapath #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
		.clk, .arst_n, .in_word, .cmd, .stat,
		.id_version_byte(id_version_byte_q),
		.page_size_code(page_size_code_q),
		.writable_pages(writable_pages_q),
		.res
	);

	bpl_ctrl #(.PAGE_BYTES(PAGE_BYTES)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .res, .cmd, .out_word
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_flash_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.kind == KIND_FLASH |-> !out_word.last)
		else $error("flash word marked last");
	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.kind == KIND_START |-> out_word.last)
		else $error("start not last");

endmodule
